[src/mis_pkg.sv]
// ----------------------------------------------------------------------------
// mis_pkg
// Shared types and constants for the independent set search core.
// ----------------------------------------------------------------------------
`default_nettype none

package mis_pkg;

  localparam int MaxVertices = 16;
  localparam int VNum        = (MaxVertices < 16) ? MaxVertices : 16;
  localparam int VW          = 4;
  localparam int CntW        = 8;
  localparam int NW          = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CHECK  = 2'd1,
    OP_SEARCH = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_A,
    S_WR_A,
    S_WR_B,
    S_LOAD,
    S_CHECK,
    S_SEARCH,
    S_EMIT,
    S_EMIT_SET
  } state_t;

  typedef struct packed {
    logic          we;
    logic [VW-1:0] waddr;
    logic [15:0]   wdata;
    logic          clr;
    logic [VW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

[src/mis_adj_mem.sv]
// ----------------------------------------------------------------------------
// mis_adj_mem
// Adjacency row memory with a registered read, row valid bits for clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module mis_adj_mem (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mis_pkg::mem_req_t req,
  output logic [15:0]            rdata
);
  import mis_pkg::*;

  logic [15:0] mem [16];
  logic [15:0] row_valid;
  logic [15:0] raw;
  logic        raw_valid;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    raw <= mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      row_valid <= '0;
      raw_valid <= 1'b0;
    end else begin
      raw_valid <= row_valid[req.raddr];
      if (req.we) begin
        row_valid[req.waddr] <= 1'b1;
      end
    end
  end

  assign rdata = raw_valid ? raw : 16'd0;

endmodule

`default_nettype wire

[src/mis_comb_step.sv]
// ----------------------------------------------------------------------------
// mis_comb_step
// Next k-combination in lexicographic order, kept as the complement of the
// mirrored selection so a same-popcount successor step walks it.
// ----------------------------------------------------------------------------
`default_nettype none

module mis_comb_step (
  input  wire logic [15:0]           u,
  input  wire logic [mis_pkg::NW-1:0] n,
  output logic [15:0]                next_u,
  output logic                       exhausted,
  output logic [15:0]                sel
);
  import mis_pkg::*;

  logic [16:0] ux;
  logic [16:0] lowbit;
  logic [16:0] ripple;
  logic [16:0] ones;
  logic [16:0] nxt;
  logic [4:0]  ctz;
  logic [4:0]  idx;

  always_comb begin
    ux     = {1'b0, u};
    lowbit = ux & (~ux + 17'd1);
    ripple = ux + lowbit;
    ctz    = 5'd0;
    for (int i = 15; i >= 0; i--) begin
      if (u[i]) ctz = 5'(i);
    end
    ones      = (ux ^ ripple) >> (ctz + 5'd2);
    nxt       = ripple | ones;
    exhausted = (u == 16'd0) || ((nxt >> n) != 17'd0);
    next_u    = nxt[15:0];
  end

  always_comb begin
    sel = '0;
    for (int i = 0; i < 16; i++) begin
      idx = n - 5'd1 - 5'(i);
      if (5'(i) < n) sel[i] = ~u[idx[3:0]];
    end
  end

endmodule

`default_nettype wire

[src/max_independent_set_search_core.sv]
// ----------------------------------------------------------------------------
// max_independent_set_search_core
// Graph store with edge insert, independence check, maximum set search, clear.
//
//   channel | direction | handshake          | payload
//   cfg     | in        | cfg_write          | cfg_data
//   request | in        | in_valid/in_stall  | operation, vertices, vertex_set
//   result  | out       | out_valid/out_stall| edge_count ... last
//
// insert: row read, two row writes, emit; an endpoint out of range goes straight to emit
// clear: goes straight to emit; check: copy the rows, test the set, emit
// search: copy the rows, then one combination tested per cycle, then one result per member
// a stalled result holds the emit state; the next request is taken from idle after it
// reset clears the row valid bits and edge count at once, no sweep
// ----------------------------------------------------------------------------
`default_nettype none

module max_independent_set_search_core (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [4:0]             cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             operation,
  input  wire logic [3:0]             first_vertex,
  input  wire logic [3:0]             second_vertex,
  input  wire logic [15:0]            vertex_set,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [7:0]                  edge_count,
  output logic                        is_independent,
  output logic                        found,
  output logic [4:0]                  set_size,
  output logic [3:0]                  vertex,
  output logic                        last
);
  import mis_pkg::*;

  state_t      state, state_next;
  op_t         op_in;
  logic [4:0]  vcount;
  logic [NW-1:0] n_cur, n_q;
  logic [VW-1:0] a_q, b_q;
  logic [15:0] set_q;
  logic [4:0]  ld_idx;
  logic [15:0] rows [16];
  logic [NW-1:0] k_q;
  logic [15:0] u_q;
  logic [CntW-1:0] edge_cnt;
  logic        res_ind;
  logic        res_found;
  logic [4:0]  res_size;
  logic [15:0] remain;
  logic        accept;
  logic        slot_free;
  mem_req_t    mreq;
  logic [15:0] rdata;
  logic [15:0] next_u;
  logic        exhausted;
  logic [15:0] sel;
  logic        sel_ok;
  logic        chk_ok;
  logic [15:0] set_masked;
  logic [3:0]  low_v;
  logic [15:0] fill;

  function automatic logic indep(input logic [15:0] m, input logic [15:0] r [16]);
    logic bad;
    bad = 1'b0;
    for (int i = 0; i < 16; i++) begin
      bad = bad | (m[i] & (|(r[i] & m)));
    end
    return ~bad;
  endfunction

  mis_adj_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mreq),
    .rdata (rdata)
  );

  mis_comb_step u_step (
    .u         (u_q),
    .n         (n_q),
    .next_u    (next_u),
    .exhausted (exhausted),
    .sel       (sel)
  );

  assign op_in     = op_t'(operation);
  assign n_cur     = (vcount > 5'(VNum)) ? 5'(VNum) : vcount;
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);
  assign sel_ok    = indep(sel, rows);
  assign set_masked = (n_q >= 5'd16) ? set_q : (set_q & ((16'd1 << n_q) - 16'd1));
  assign chk_ok    = indep(set_masked, rows);
  assign fill      = 16'((17'd1 << (5'(n_q) - k_q + 5'd1)) - 17'd1);

  always_comb begin
    low_v = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (remain[i]) low_v = 4'(i);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op_in)
            OP_INSERT: state_next = ((first_vertex >= n_cur[3:0] && n_cur < 5'd16) ||
                                     (second_vertex >= n_cur[3:0] && n_cur < 5'd16))
                                    ? S_EMIT : S_RD_A;
            OP_CHECK:  state_next = S_LOAD;
            OP_SEARCH: state_next = S_LOAD;
            OP_CLEAR:  state_next = S_EMIT;
            default:   state_next = S_EMIT;
          endcase
        end
      end
      S_RD_A: state_next = S_WR_A;
      S_WR_A: state_next = S_WR_B;
      S_WR_B: state_next = S_EMIT;
      S_LOAD: begin
        if (ld_idx == 5'd16) begin
          if (res_ind) state_next = S_CHECK;
          else if (n_q == 5'd0) state_next = S_EMIT;
          else state_next = S_SEARCH;
        end
      end
      S_CHECK: state_next = S_EMIT;
      S_SEARCH: begin
        if (sel_ok) state_next = S_EMIT_SET;
        else if (exhausted && k_q == 5'd1) state_next = S_EMIT;
      end
      S_EMIT: if (slot_free) state_next = S_IDLE;
      S_EMIT_SET: if (slot_free && $countones(remain) == 1) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory requests
  always_comb begin
    mreq       = '0;
    mreq.raddr = ld_idx[3:0];
    unique case (state)
      S_IDLE: mreq.clr = accept && (op_in == OP_CLEAR);
      S_RD_A: mreq.raddr = a_q;
      S_WR_A: begin
        mreq.raddr = b_q;
        mreq.we    = 1'b1;
        mreq.waddr = a_q;
        mreq.wdata = rdata | (16'd1 << b_q);
      end
      S_WR_B: begin
        mreq.we    = 1'b1;
        mreq.waddr = b_q;
        mreq.wdata = rdata | (16'd1 << a_q);
      end
      default: mreq.raddr = ld_idx[3:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vcount    <= 5'(16);
      edge_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) vcount <= cfg_data;
      if (state == S_IDLE && accept && op_in == OP_CLEAR) edge_cnt <= '0;
      if (state == S_WR_A && !rdata[b_q] && edge_cnt != 8'hFF) edge_cnt <= edge_cnt + 8'd1;
      if ((state == S_EMIT || state == S_EMIT_SET) && slot_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // item datapath; res_ind marks a swept check until its answer is in
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          n_q       <= n_cur;
          a_q       <= first_vertex;
          b_q       <= second_vertex;
          set_q     <= vertex_set;
          ld_idx    <= 5'd0;
          res_ind   <= (op_in == OP_CHECK);
          res_found <= 1'b0;
          res_size  <= 5'd0;
        end
      end
      S_LOAD: begin
        ld_idx <= ld_idx + 5'd1;
        if (ld_idx != 5'd0) rows[4'(ld_idx - 5'd1)] <= rdata;
        k_q <= n_q;
        u_q <= 16'd0;
      end
      S_CHECK: res_ind <= chk_ok;
      S_SEARCH: begin
        if (sel_ok) begin
          remain    <= sel;
          res_found <= 1'b1;
          res_size  <= k_q;
        end else if (exhausted) begin
          k_q <= k_q - 5'd1;
          u_q <= fill;
        end else begin
          u_q <= next_u;
        end
      end
      S_EMIT_SET: if (slot_free) remain <= remain & ~(16'd1 << low_v);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT || state == S_EMIT_SET) && slot_free) begin
      edge_count     <= edge_cnt;
      is_independent <= (state == S_EMIT) && res_ind;
      found          <= (state == S_EMIT_SET) && res_found;
      set_size       <= (state == S_EMIT_SET) ? res_size : 5'd0;
      vertex         <= (state == S_EMIT_SET) ? low_v : 4'd0;
      last           <= (state == S_EMIT) || ($countones(remain) == 1);
    end
  end

  a_stall_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> state == S_IDLE) else $error("request taken while busy");
  a_set_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT_SET |-> remain != 16'd0) else $error("empty set emitted");
  a_found_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> set_size != 5'd0) else $error("found with zero size");
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    edge_cnt <= 8'(VNum * (VNum + 1) / 2)) else $error("edge count too large");

endmodule

`default_nettype wire

[dv/mis_checker.sv]
// ----------------------------------------------------------------------------
// mis_checker
// Watches the request, result and register channels of the search core,
// keeps its own copy of the graph, predicts every result and compares.
// ----------------------------------------------------------------------------
module mis_checker
  import mis_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [3:0]  first_vertex,
  input  logic [3:0]  second_vertex,
  input  logic [15:0] vertex_set,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  edge_count,
  input  logic        is_independent,
  input  logic        found,
  input  logic [4:0]  set_size,
  input  logic [3:0]  vertex,
  input  logic        last,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] edges;
    logic       indep;
    logic       fnd;
    logic [4:0] size;
    logic [3:0] vtx;
    logic       lst;
  } result_t;

  result_t     expected_results[$];
  logic [15:0] graph_rows[16];
  logic [7:0]  graph_edges;
  logic [4:0]  active_vertices;

  function automatic int vertices_in_use();
    return (active_vertices > 16) ? 16 : int'(active_vertices);
  endfunction

  function automatic bit no_conflict(logic [15:0] mask, int n);
    for (int v = 0; v < n; v++)
      if (mask[v] && (graph_rows[v] & mask) != 0) return 0;
    return 1;
  endfunction

  function automatic void push_result(bit indep, bit fnd, int size, int vtx, bit lst);
    result_t r;
    r.edges = graph_edges;
    r.indep = indep;
    r.fnd = fnd;
    r.size = size[4:0];
    r.vtx = vtx[3:0];
    r.lst = lst;
    expected_results.push_back(r);
  endfunction

  // lexicographic walk over k-subsets of n vertices
  function automatic bit find_set(int n, int k, ref int pick[16]);
    logic [15:0] mask;
    int j;
    for (int i = 0; i < k; i++) pick[i] = i;
    forever begin
      mask = '0;
      for (int i = 0; i < k; i++) mask[pick[i]] = 1'b1;
      if (no_conflict(mask, n)) return 1;
      j = k - 1;
      while (j >= 0 && pick[j] >= n - k + j) j--;
      if (j < 0) return 0;
      pick[j]++;
      for (int i = j + 1; i < k; i++) pick[i] = pick[i-1] + 1;
    end
  endfunction

  function automatic void predict_request(op_t op, int a, int b, logic [15:0] set);
    int n;
    int pick[16];
    n = vertices_in_use();
    case (op)
      OP_INSERT: begin
        if (a < n && b < n) begin
          if (!graph_rows[a][b] && graph_edges != 8'hFF) graph_edges++;
          graph_rows[a][b] = 1'b1;
          graph_rows[b][a] = 1'b1;
        end
        push_result(0, 0, 0, 0, 1);
      end
      OP_CHECK: begin
        push_result(no_conflict(set & ((n >= 16) ? 16'hFFFF : (16'h1 << n) - 16'h1), n),
                    0, 0, 0, 1);
      end
      OP_SEARCH: begin
        for (int k = n; k >= 1; k--) begin
          if (find_set(n, k, pick)) begin
            for (int i = 0; i < k; i++) push_result(0, 1, k, pick[i], i == k - 1);
            return;
          end
        end
        push_result(0, 0, 0, 0, 1);
      end
      default: begin
        foreach (graph_rows[i]) graph_rows[i] = '0;
        graph_edges = '0;
        push_result(0, 0, 0, 0, 1);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      foreach (graph_rows[i]) graph_rows[i] = '0;
      graph_edges = '0;
      active_vertices = 5'd16;
      fail_count = 0;
      expected_results.delete();
      pending = 0;
    end else begin
      if (cfg_write) active_vertices = cfg_data;
      if (in_valid && !in_stall)
        predict_request(op_t'(operation), first_vertex, second_vertex, vertex_set);
      if (out_valid && !out_stall) begin
        got = {edge_count, is_independent, found, set_size, vertex, last};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.edges !== want.edges || got.indep !== want.indep ||
              got.fnd !== want.fnd || got.size !== want.size ||
              got.vtx !== want.vtx || got.lst !== want.lst) begin
            $display("%0t: mismatch expected e=%0d i=%0d f=%0d s=%0d v=%0d l=%0d",
                     $time, want.edges, want.indep, want.fnd, want.size, want.vtx,
                     want.lst);
            $display("%0t:          actual   e=%0d i=%0d f=%0d s=%0d v=%0d l=%0d",
                     $time, got.edges, got.indep, got.fnd, got.size, got.vtx, got.lst);
            fail_count++;
          end
        end
      end
      pending = expected_results.size();
    end
  end
endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives graph requests and vertex count changes into the search core with
// bursty traffic and a stalling receiver; the checker gives the verdict count.
// ----------------------------------------------------------------------------
module tb;
  import mis_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_write = 0;
  logic [4:0]  cfg_data = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  operation = 0;
  logic [3:0]  first_vertex = 0;
  logic [3:0]  second_vertex = 0;
  logic [15:0] vertex_set = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [7:0]  edge_count;
  logic        is_independent;
  logic        found;
  logic [4:0]  set_size;
  logic [3:0]  vertex;
  logic        last;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  max_independent_set_search_core u_dut (.*);
  mis_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 100000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stalls in phases: none, light, heavy
  always @(posedge clk) begin
    case ((cycles / 500) % 3)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(3, 0) == 0);
      default: out_stall <= ($urandom_range(3, 0) != 0);
    endcase
  end

  task automatic send(op_t op, logic [3:0] a, logic [3:0] b, logic [15:0] s);
    if (gap_left == 0 && burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(5, 1);
    end
    while (gap_left > 0) begin
      gap_left--;
      @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    operation <= op;
    first_vertex <= a;
    second_vertex <= b;
    vertex_set <= s;
    do @(posedge clk); while (in_stall);
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic settle_and_config(logic [4:0] n);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    cfg_write <= 1'b0;
    burst_left = 0;
    gap_left = 0;
  endtask

  task automatic random_phase(int count, int n);
    int r;
    int hi;
    hi = (n == 0) ? 15 : ((n > 16) ? 15 : n - 1);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99, 0);
      if (r < 45)
        send(OP_INSERT, ($urandom_range(9, 0) == 0) ? 4'($urandom) : 4'($urandom_range(hi, 0)),
             4'($urandom_range(hi, 0)), 16'($urandom));
      else if (r < 75)
        send(OP_CHECK, 4'($urandom), 4'($urandom), 16'($urandom));
      else if (r < 92)
        send(OP_SEARCH, 4'($urandom), 4'($urandom), 16'($urandom));
      else
        send(OP_CLEAR, 4'($urandom), 4'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty graph, extremes, self-loop, duplicate edge
    send(OP_CHECK, 0, 0, 16'h0000);
    send(OP_CHECK, 0, 0, 16'hFFFF);
    send(OP_INSERT, 0, 15, 0);
    send(OP_INSERT, 15, 0, 0);
    send(OP_INSERT, 15, 15, 0);
    send(OP_INSERT, 7, 8, 0);
    send(OP_CHECK, 0, 0, 16'h8001);
    send(OP_CHECK, 0, 0, 16'h8000);
    send(OP_CHECK, 0, 0, 16'h0180);
    send(OP_CHECK, 0, 0, 16'h5A5A);
    send(OP_SEARCH, 0, 0, 0);
    send(OP_CLEAR, 15, 15, 16'hFFFF);
    send(OP_SEARCH, 0, 0, 0);
    settle_and_config(5'd4);
    for (int v = 0; v < 4; v++) send(OP_INSERT, v[3:0], v[3:0], 0);
    send(OP_INSERT, 9, 2, 0);
    send(OP_CHECK, 0, 0, 16'hFFF0);
    send(OP_SEARCH, 0, 0, 0);
    settle_and_config(5'd0);
    send(OP_INSERT, 0, 0, 0);
    send(OP_CHECK, 0, 0, 16'hFFFF);
    send(OP_SEARCH, 0, 0, 0);
    settle_and_config(5'd31);
    send(OP_CLEAR, 0, 0, 0);
    send(OP_SEARCH, 0, 0, 0);
    // random phases over several vertex counts
    random_phase(90, 31);
    settle_and_config(5'd8);
    random_phase(80, 8);
    settle_and_config(5'd1);
    random_phase(40, 1);
    settle_and_config(5'd12);
    random_phase(80, 12);
    settle_and_config(5'd16);
    random_phase(120, 16);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

[sim.f]
src/mis_pkg.sv
src/mis_adj_mem.sv
src/mis_comb_step.sv
src/max_independent_set_search_core.sv
dv/mis_checker.sv
dv/tb.sv
